// ===== sv/alpha_bounding_box_trim_defines.svh =====
`ifndef ALPHA_BOUNDING_BOX_TRIM_DEFINES_SVH
`define ALPHA_BOUNDING_BOX_TRIM_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define ABBT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("abbt assertion failed");

// next-cycle implication, checked while out of reset
`define ABBT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("abbt assertion failed");

`endif

// ===== sv/abbt_pkg.sv =====
`default_nettype none

package abbt_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int POS_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = POS_W + 1;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int ALPHA_W   = 8;
    localparam int DATA_IN_W = 8;
    localparam int DATA_OUT_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [POS_W-1:0] RESET_LAST = POS_W'(255);

    // size register to index of the last pixel, zero treated as one
    function automatic logic [POS_W-1:0] clamp_last(input logic [CFG_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (32'(v) > MAX_DIM) begin
            r = POS_W'(MAX_DIM - 1);
        end else begin
            r = POS_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/alpha_bounding_box_trim.sv =====
// result: registered, valid in the cycle after the final pixel of a frame is accepted
// throughput: one pixel per clock, the only stall is a result not yet taken
// frame size comes from two write-only registers, a write restarts the frame
// reset: counters and bounds cleared, frame size back to 256 x 256
`default_nettype none

`include "alpha_bounding_box_trim_defines.svh"

module alpha_bounding_box_trim
    import abbt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_IN_W-1:0]  s_tdata,   // alpha[7:0]

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_OUT_W-1:0]      m_tdata,   // crop_width, crop_height, crop_x, crop_y
    output logic                       m_tuser    // is_empty
);

    logic [POS_W-1:0] w_last_reg, h_last_reg;
    logic [POS_W-1:0] col_reg, row_reg;
    logic [POS_W-1:0] min_col_reg, min_row_reg;
    logic [DIM_W-1:0] max_col_end_reg, max_row_end_reg;
    logic             seen_reg;

    logic [POS_W-1:0] min_col_next, min_row_next;
    logic [DIM_W-1:0] max_col_end_next, max_row_end_next;
    logic             seen_next;

    logic             out_valid_reg;
    logic [DIM_W-1:0] crop_w_reg, crop_h_reg;
    logic [POS_W-1:0] crop_x_reg, crop_y_reg;
    logic             empty_reg;

    logic             accept;
    logic             opaque;
    logic             last_col, last_row;
    logic [DIM_W-1:0] col_end, row_end;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign opaque   = s_tdata[ALPHA_W-1:0] != '0;
    assign col_end  = {1'b0, col_reg} + DIM_W'(1);
    assign row_end  = {1'b0, row_reg} + DIM_W'(1);
    assign last_col = col_reg == w_last_reg;
    assign last_row = row_reg == h_last_reg;

    always_comb begin
        min_col_next     = min_col_reg;
        min_row_next     = min_row_reg;
        max_col_end_next = max_col_end_reg;
        max_row_end_next = max_row_end_reg;
        seen_next        = seen_reg;
        if (opaque) begin
            if (!seen_reg) begin
                min_col_next     = col_reg;
                min_row_next     = row_reg;
                max_col_end_next = col_end;
                max_row_end_next = row_end;
                seen_next        = 1'b1;
            end else begin
                if (col_reg < min_col_reg) begin
                    min_col_next = col_reg;
                end
                if (col_end > max_col_end_reg) begin
                    max_col_end_next = col_end;
                end
                max_row_end_next = row_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg      <= RESET_LAST;
            h_last_reg      <= RESET_LAST;
            col_reg         <= '0;
            row_reg         <= '0;
            min_col_reg     <= '0;
            min_row_reg     <= '0;
            max_col_end_reg <= '0;
            max_row_end_reg <= '0;
            seen_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en && (cfg_addr == CFG_IMAGE_WIDTH || cfg_addr == CFG_IMAGE_HEIGHT)) begin
                if (cfg_addr == CFG_IMAGE_WIDTH) begin
                    w_last_reg <= clamp_last(cfg_wdata);
                end else begin
                    h_last_reg <= clamp_last(cfg_wdata);
                end
                col_reg         <= '0;
                row_reg         <= '0;
                min_col_reg     <= '0;
                min_row_reg     <= '0;
                max_col_end_reg <= '0;
                max_row_end_reg <= '0;
                seen_reg        <= 1'b0;
            end else if (accept) begin
                if (!last_col) begin
                    col_reg         <= col_reg + POS_W'(1);
                    min_col_reg     <= min_col_next;
                    min_row_reg     <= min_row_next;
                    max_col_end_reg <= max_col_end_next;
                    max_row_end_reg <= max_row_end_next;
                    seen_reg        <= seen_next;
                end else if (!last_row) begin
                    col_reg         <= '0;
                    row_reg         <= row_reg + POS_W'(1);
                    min_col_reg     <= min_col_next;
                    min_row_reg     <= min_row_next;
                    max_col_end_reg <= max_col_end_next;
                    max_row_end_reg <= max_row_end_next;
                    seen_reg        <= seen_next;
                end else begin
                    out_valid_reg   <= 1'b1;
                    col_reg         <= '0;
                    row_reg         <= '0;
                    min_col_reg     <= '0;
                    min_row_reg     <= '0;
                    max_col_end_reg <= '0;
                    max_row_end_reg <= '0;
                    seen_reg        <= 1'b0;
                end
            end
        end
    end

    // result payload, loaded on the final pixel of a frame
    always_ff @(posedge aclk) begin
        if (accept && last_col && last_row) begin
            if (seen_next) begin
                crop_w_reg <= max_col_end_next - {1'b0, min_col_next};
                crop_h_reg <= max_row_end_next - {1'b0, min_row_next};
                crop_x_reg <= min_col_next;
                crop_y_reg <= min_row_next;
                empty_reg  <= 1'b0;
            end else begin
                crop_w_reg <= '0;
                crop_h_reg <= '0;
                crop_x_reg <= '0;
                crop_y_reg <= '0;
                empty_reg  <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = empty_reg;
    assign m_tdata  = {(DATA_OUT_W - 2*DIM_W - 2*POS_W)'(0),
                       crop_y_reg, crop_x_reg, crop_h_reg, crop_w_reg};

    `ABBT_ASSERT_NOW(a_col_in_row, aclk, aresetn, 1'b1, col_reg <= w_last_reg)
    `ABBT_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `ABBT_ASSERT_NOW(a_box_nonzero, aclk, aresetn, m_tvalid && !m_tuser,
        crop_w_reg != '0 && crop_h_reg != '0)
    `ABBT_ASSERT_NEXT(a_frame_restart, aclk, aresetn, accept && last_col && last_row,
        m_tvalid && !seen_reg)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import abbt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [11:0] x;
        logic [11:0] y;
        logic        empty;
    } crop_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata   = '0;   // alpha[7:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;          // crop_width, crop_height, crop_x, crop_y
    logic                  m_tuser;          // is_empty

    // bounding box tracker state
    logic [CFG_W-1:0] frame_w_reg = 13'd256;
    logic [CFG_W-1:0] frame_h_reg = 13'd256;
    logic [11:0]      col_pos;
    logic [11:0]      row_pos;
    logic [11:0]      first_col;
    logic [11:0]      first_row;
    logic [12:0]      col_end;
    logic [12:0]      row_end;
    bit               any_opaque;

    crop_t crop_q[$];
    int    mismatch_count = 0;
    int    pixels_sent    = 0;
    bit    tx_idle_on     = 1'b1;
    bit    rx_idle_on     = 1'b1;
    int    rx_hold        = 0;

    alpha_bounding_box_trim DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [12:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [12:0] r;
        if (v == '0) begin
            r = 13'd1;
        end else if (v > MAX_DIM) begin
            r = 13'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic void frame_restart();
        col_pos    = '0;
        row_pos    = '0;
        first_col  = '0;
        first_row  = '0;
        col_end    = '0;
        row_end    = '0;
        any_opaque = 1'b0;
    endfunction

    function automatic void track_pixel(input logic [7:0] a);
        logic [12:0] col_next;
        logic [12:0] row_next;
        crop_t       r;
        col_next = {1'b0, col_pos} + 13'd1;
        row_next = {1'b0, row_pos} + 13'd1;
        if (a != '0) begin
            if (!any_opaque) begin
                first_col  = col_pos;
                col_end    = col_next;
                first_row  = row_pos;
                row_end    = row_next;
                any_opaque = 1'b1;
            end else begin
                if (col_pos < first_col) begin
                    first_col = col_pos;
                end
                if (col_next > col_end) begin
                    col_end = col_next;
                end
                row_end = row_next;
            end
        end
        if (col_next < eff_dim(frame_w_reg)) begin
            col_pos = col_pos + 12'd1;
        end else begin
            col_pos = '0;
            if (row_next < eff_dim(frame_h_reg)) begin
                row_pos = row_pos + 12'd1;
            end else begin
                if (any_opaque) begin
                    r = '{col_end - {1'b0, first_col}, row_end - {1'b0, first_row},
                          first_col, first_row, 1'b0};
                end else begin
                    r = '{13'd0, 13'd0, 12'd0, 12'd0, 1'b1};
                end
                crop_q.push_back(r);
                frame_restart();
            end
        end
    endfunction

    always @(posedge aclk) begin : crop_checker
        crop_t got;
        crop_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[12:0], m_tdata[25:13], m_tdata[37:26], m_tdata[49:38], m_tuser};
            if (crop_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected crop transaction: w=%0d h=%0d x=%0d y=%0d empty=%0d",
                             got.width, got.height, got.x, got.y, got.empty);
                end
            end else begin
                want = crop_q.pop_front();
                if (got.width !== want.width || got.height !== want.height ||
                    got.x !== want.x || got.y !== want.y || got.empty !== want.empty) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("crop mismatch: expected w=%0d h=%0d x=%0d y=%0d empty=%0d",
                                 want.width, want.height, want.x, want.y, want.empty);
                        $display("               actual   w=%0d h=%0d x=%0d y=%0d empty=%0d",
                                 got.width, got.height, got.x, got.y, got.empty);
                    end
                end
            end
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_idle_on && $urandom_range(99) < 23) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_pixel(input logic [7:0] a);
        if (tx_idle_on && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        do @(posedge aclk); while (!s_tready);
        track_pixel(a);
        pixels_sent++;
    endtask

    task automatic stop_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drain();
        stop_stream();
        while (crop_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) begin
            frame_w_reg = val;
            frame_restart();
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            frame_h_reg = val;
            frame_restart();
        end
    endtask

    // density: 0 transparent, 1 sparse, 2 medium, 3 mostly opaque
    task automatic send_frame(input int density);
        int pct;
        int n;
        pct = (density == 0) ? 0 : (density == 1) ? 3 : (density == 2) ? 25 : 90;
        n   = int'(eff_dim(frame_w_reg)) * int'(eff_dim(frame_h_reg));
        repeat (n) begin
            send_pixel(($urandom_range(99) < pct) ? 8'($urandom_range(1, 255)) : 8'd0);
        end
    endtask

    task automatic test_reset_size();
        // a partial frame at the reset size, past the first row, gives no result
        for (int i = 0; i < 300; i++) begin
            send_pixel((i == 3 || i == 290) ? 8'd255 : 8'd0);
        end
        wait_drain();
    endtask

    task automatic test_single_pixel();
        // zero size is taken as one
        cfg_write(CFG_IMAGE_WIDTH, '0);
        cfg_write(CFG_IMAGE_HEIGHT, '0);
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd128);
        send_pixel(8'd255);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        wait_drain();
    endtask

    task automatic test_small_frames();
        cfg_write(CFG_IMAGE_WIDTH, 13'd4);
        cfg_write(CFG_IMAGE_HEIGHT, 13'd2);
        // first column moves left on the second row
        send_pixel(8'd0); send_pixel(8'd0); send_pixel(8'd5); send_pixel(8'd0);
        send_pixel(8'd0); send_pixel(8'd1); send_pixel(8'd0); send_pixel(8'd0);
        cfg_write(CFG_IMAGE_WIDTH, 13'd2);
        repeat (4) send_pixel(8'd0);
        wait_drain();
    endtask

    task automatic test_mid_frame_write();
        cfg_write(CFG_IMAGE_WIDTH, 13'd3);
        cfg_write(CFG_IMAGE_HEIGHT, 13'd2);
        send_pixel(8'd9); send_pixel(8'd0); send_pixel(8'd7); send_pixel(8'd0);
        // a size write drops the partial frame
        cfg_write(CFG_IMAGE_WIDTH, 13'd3);
        send_pixel(8'd0); send_pixel(8'd0);
        // writes to unused indexes leave the frame alone
        cfg_write(CFG_UNUSED_2, 13'h1FFF);
        send_pixel(8'd0); send_pixel(8'd4);
        cfg_write(CFG_UNUSED_3, 13'h0AAA);
        send_pixel(8'd0); send_pixel(8'd0);
        wait_drain();
    endtask

    task automatic test_max_dims();
        // sizes above the limit are clamped, so no frame ends early
        cfg_write(CFG_IMAGE_HEIGHT, 13'd1);
        cfg_write(CFG_IMAGE_WIDTH, 13'(MAX_DIM + 3));
        repeat (150) send_pixel(8'd200);
        cfg_write(CFG_IMAGE_WIDTH, 13'd1);
        cfg_write(CFG_IMAGE_HEIGHT, 13'(MAX_DIM + 2));
        repeat (150) send_pixel(8'd77);
        wait_drain();
    endtask

    task automatic test_backpressure();
        cfg_write(CFG_IMAGE_WIDTH, 13'd1);
        cfg_write(CFG_IMAGE_HEIGHT, 13'd1);
        tx_idle_on = 1'b0;
        rx_hold    = 200;
        repeat (40) send_pixel(8'($urandom_range(0, 1) * $urandom_range(1, 255)));
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        cfg_write(CFG_IMAGE_WIDTH, 13'd3);
        cfg_write(CFG_IMAGE_HEIGHT, 13'd3);
        repeat (4) begin
            send_frame(2);
            wait_drain();
        end
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        cfg_write(CFG_IMAGE_WIDTH, 13'd6);
        cfg_write(CFG_IMAGE_HEIGHT, 13'd4);
        repeat (6) send_frame($urandom_range(0, 3));
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random();
        int start_count;
        start_count = pixels_sent;
        while (pixels_sent - start_count < 950) begin
            cfg_write(CFG_IMAGE_WIDTH, 13'($urandom_range(0, 10)));
            if ($urandom_range(3) != 0) begin
                cfg_write(CFG_IMAGE_HEIGHT, 13'($urandom_range(0, 10)));
            end
            if ($urandom_range(9) == 0) begin
                cfg_write($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                          13'($urandom_range(0, 8191)));
            end
            repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 3));
            // stray pixels; any partial frame left is dropped by the next size write
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 5)) send_pixel(8'($urandom_range(0, 255)));
            end
        end
        wait_drain();
    endtask

    initial begin
        int wait_cycles;
        frame_restart();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_single_pixel();
        test_small_frames();
        test_mid_frame_write();
        test_max_dims();
        test_backpressure();
        test_sender_pause();
        test_no_idle();
        test_random();
        stop_stream();
        wait_cycles = 0;
        while (crop_q.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (5) @(posedge aclk);
        mismatch_count += crop_q.size();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== alpha_bounding_box_trim.f =====
+incdir+sv
sv/abbt_pkg.sv
sv/alpha_bounding_box_trim.sv
test/tb_top.sv
